// ===== src/rtpe_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpe_pkg: shared types and constants for range to prefix expansion
// Range descriptor passed from the front end to the expansion engine,
// engine state encoding and the per-range prefix limit.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpe_pkg;

  parameter int unsigned FIELD_W     = 16;
  parameter int unsigned LEN_W       = 5;
  parameter int unsigned MAX_RESULTS = 30;
  parameter int unsigned CNT_W       = $clog2(MAX_RESULTS);

  typedef struct packed {
    logic [FIELD_W-1:0] low;
    logic [FIELD_W-1:0] high;
    logic               empty;
  } desc_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

endpackage

`default_nettype wire

// ===== src/rtpe_front.sv =====
// ----------------------------------------------------------------------------
// rtpe_front: range intake and classification
// Masks both bounds to WIDTH bits, flags inverted ranges and pushes one
// descriptor per accepted transaction into the range queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpe_front #(
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [rtpe_pkg::FIELD_W-1:0]  range_low,
  input  wire logic [rtpe_pkg::FIELD_W-1:0]  range_high,
  input  wire logic                          q_full,
  output logic                               q_push,
  output rtpe_pkg::desc_t                    q_wdata
);

  localparam logic [32:0] MASK = (33'd1 << WIDTH) - 33'd1;

  logic [rtpe_pkg::FIELD_W-1:0] low_m;
  logic [rtpe_pkg::FIELD_W-1:0] high_m;

  assign low_m  = range_low  & MASK[rtpe_pkg::FIELD_W-1:0];
  assign high_m = range_high & MASK[rtpe_pkg::FIELD_W-1:0];

  assign in_tready     = !q_full;
  assign q_push        = in_tvalid && !q_full;
  assign q_wdata.low   = low_m;
  assign q_wdata.high  = high_m;
  assign q_wdata.empty = (low_m > high_m);

endmodule

`default_nettype wire

// ===== src/rtpe_queue.sv =====
// ----------------------------------------------------------------------------
// rtpe_queue: two-entry range descriptor FIFO
// Decouples range intake from prefix expansion.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpe_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire rtpe_pkg::desc_t  wdata,
  output logic                  full,
  input  wire logic             pop,
  output rtpe_pkg::desc_t       rdata,
  output logic                  avail
);

  rtpe_pkg::desc_t mem_r [2];
  logic            wp_r;
  logic            wp_nxt;
  logic            rp_r;
  logic            rp_nxt;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop  ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(pop && !avail))
    else $error("rtpe_queue: pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("rtpe_queue: push into full queue");

endmodule

`default_nettype wire

// ===== src/rtpe_back.sv =====
// ----------------------------------------------------------------------------
// rtpe_back: prefix expansion engine
// Walks a cursor from low to high+1 or the prefix limit, emitting one prefix
// aligned block per cycle, unless stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpe_back #(
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_avail,
  input  wire rtpe_pkg::desc_t               q_rdata,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [rtpe_pkg::FIELD_W-1:0]       prefix_value,
  output logic [rtpe_pkg::LEN_W-1:0]         prefix_len,
  output logic                               empty_range,
  output logic                               last
);

  localparam int unsigned CW = WIDTH + 1;
  localparam int unsigned ZW = $clog2(WIDTH + 1);
  localparam logic [rtpe_pkg::CNT_W-1:0] CNT_LAST =
    rtpe_pkg::CNT_W'(rtpe_pkg::MAX_RESULTS - 1);

  function automatic logic [ZW-1:0] tzc(input logic [CW-1:0] v);
    logic [ZW-1:0] n;
    n = ZW'(WIDTH);
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (v[i]) n = ZW'(i);
    end
    return n;
  endfunction

  function automatic logic [ZW-1:0] msb(input logic [CW-1:0] v);
    logic [ZW-1:0] n;
    n = '0;
    for (int i = 0; i < CW; i++) begin
      if (v[i]) n = ZW'(i);
    end
    return n;
  endfunction

  rtpe_pkg::bk_state_t          state_r;
  rtpe_pkg::bk_state_t          state_nxt;
  logic [CW-1:0]                cur_r;
  logic [CW-1:0]                cur_nxt;
  logic [CW-1:0]                end_r;
  logic [CW-1:0]                end_nxt;
  logic [rtpe_pkg::CNT_W-1:0]   cnt_r;
  logic [rtpe_pkg::CNT_W-1:0]   cnt_nxt;
  logic                         ov_r;
  logic                         ov_nxt;
  logic [rtpe_pkg::FIELD_W-1:0] val_r;
  logic [rtpe_pkg::FIELD_W-1:0] val_nxt;
  logic [rtpe_pkg::LEN_W-1:0]   len_r;
  logic [rtpe_pkg::LEN_W-1:0]   len_nxt;
  logic                         emp_r;
  logic                         emp_nxt;
  logic                         last_r;
  logic                         last_nxt;

  logic                         slot_free;
  logic [CW-1:0]                rem;
  logic [ZW-1:0]                tz;
  logic [ZW-1:0]                lg;
  logic [ZW-1:0]                z;
  logic [CW-1:0]                step_cur;
  logic                         step_last;
  logic [5:0]                   len_full;
  logic                         emit;

  assign slot_free = !ov_r || out_tready;
  assign rem       = end_r - cur_r;
  assign tz        = tzc(cur_r);
  assign lg        = msb(rem);
  assign z         = (tz < lg) ? tz : lg;
  assign step_cur  = cur_r + (CW'(1) << z);
  assign step_last = (step_cur >= end_r) || (cnt_r == CNT_LAST);
  assign len_full  = 6'(WIDTH) - 6'(z);
  assign emit      = (state_r == rtpe_pkg::BK_RUN) && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtpe_pkg::BK_IDLE: begin
        if (q_avail && slot_free && !q_rdata.empty) state_nxt = rtpe_pkg::BK_RUN;
      end
      rtpe_pkg::BK_RUN: begin
        if (slot_free && step_last) state_nxt = rtpe_pkg::BK_IDLE;
      end
      default: state_nxt = rtpe_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    cur_nxt  = cur_r;
    end_nxt  = end_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r && !out_tready;
    val_nxt  = val_r;
    len_nxt  = len_r;
    emp_nxt  = emp_r;
    last_nxt = last_r;
    unique case (state_r)
      rtpe_pkg::BK_IDLE: begin
        if (q_avail && slot_free) begin
          q_pop = 1'b1;
          if (q_rdata.empty) begin
            ov_nxt   = 1'b1;
            val_nxt  = '0;
            len_nxt  = '0;
            emp_nxt  = 1'b1;
            last_nxt = 1'b1;
          end else begin
            cur_nxt = CW'(q_rdata.low);
            end_nxt = CW'(q_rdata.high) + CW'(1);
            cnt_nxt = '0;
          end
        end
      end
      rtpe_pkg::BK_RUN: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          val_nxt  = rtpe_pkg::FIELD_W'(cur_r);
          len_nxt  = len_full[rtpe_pkg::LEN_W-1:0];
          emp_nxt  = 1'b0;
          last_nxt = step_last;
          cur_nxt  = step_cur;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtpe_pkg::BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    end_r  <= end_nxt;
    cnt_r  <= cnt_nxt;
    val_r  <= val_nxt;
    len_r  <= len_nxt;
    emp_r  <= emp_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid   = ov_r;
  assign prefix_value = val_r;
  assign prefix_len   = len_r;
  assign empty_range  = emp_r;
  assign last         = last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtpe_pkg::BK_RUN) |-> (cur_r < end_r))
    else $error("rtpe_back: cursor reached range end while running");
  assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (step_cur <= end_r))
    else $error("rtpe_back: prefix block overruns range end");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == rtpe_pkg::BK_IDLE))
    else $error("rtpe_back: descriptor taken while expanding");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtpe_pkg::BK_RUN) |-> (cnt_r <= CNT_LAST))
    else $error("rtpe_back: prefix count beyond limit");

endmodule

`default_nettype wire

// ===== src/range_to_prefix_expansion.sv =====
// ----------------------------------------------------------------------------
// range_to_prefix_expansion: inclusive range to TCAM prefix list
// Splits [low, high] into the ascending list of aligned prefix blocks.
// ----------------------------------------------------------------------------
// With the engine idle, a range passes the queue, the cursor load and the
//   output register before its first prefix is valid; an empty range passes
//   the queue and the output register. One prefix per cycle unless the
//   output stalls, N <= 2*WIDTH-2 per range, capped at 30; the next range
//   loads after the last prefix. A two-entry queue buffers waiting ranges.
// Reset (rst_n low, synchronous) empties the queue and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module range_to_prefix_expansion #(
  parameter int unsigned WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] range_low, [31:16] range_high
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [15:0] prefix_value, [20:16] prefix_len, zero pad
  output logic             out_tuser,  // [0] empty_range
  output logic             out_tlast
);

  rtpe_pkg::desc_t              q_wdata;
  rtpe_pkg::desc_t              q_rdata;
  logic                         q_push;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_avail;
  logic [rtpe_pkg::FIELD_W-1:0] prefix_value;
  logic [rtpe_pkg::LEN_W-1:0]   prefix_len;

  rtpe_front #(
    .WIDTH (WIDTH)
  ) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .range_low  (in_tdata[15:0]),
    .range_high (in_tdata[31:16]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  rtpe_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .avail (q_avail)
  );

  rtpe_back #(
    .WIDTH (WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_avail      (q_avail),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .prefix_value (prefix_value),
    .prefix_len   (prefix_len),
    .empty_range  (out_tuser),
    .last         (out_tlast)
  );

  assign out_tdata = {3'b000, prefix_len, prefix_value};

endmodule

`default_nettype wire
